/* rtl/core/euler_to_quaternion_macros.svh */
// Assertion macros for the euler_to_quaternion core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
`ifndef ASSERT_OFF
`define E2Q_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("e2q check failed");
`define E2Q_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("e2q never failed");
`else
`define E2Q_ASSERT(lbl, clk, rst, prop)
`define E2Q_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* rtl/core/e2q_pkg.sv */
// Shared types, constants and the CORDIC angle table for euler_to_quaternion.
// No dependencies.
package e2q_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int IDX_W = 5;

  localparam logic signed [32:0] GAIN_Q30   = 33'sd652032874;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [26:0] z;
    logic               flip;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  function automatic logic signed [26:0] atan_q24(input logic [IDX_W-1:0] i);
    logic signed [26:0] r;
    unique case (i)
      5'd0:  r = 27'sd13176795;
      5'd1:  r = 27'sd7778716;
      5'd2:  r = 27'sd4110060;
      5'd3:  r = 27'sd2086331;
      5'd4:  r = 27'sd1047214;
      5'd5:  r = 27'sd524117;
      5'd6:  r = 27'sd262123;
      5'd7:  r = 27'sd131069;
      5'd8:  r = 27'sd65536;
      5'd9:  r = 27'sd32768;
      5'd10: r = 27'sd16384;
      5'd11: r = 27'sd8192;
      5'd12: r = 27'sd4096;
      5'd13: r = 27'sd2048;
      5'd14: r = 27'sd1024;
      5'd15: r = 27'sd512;
      5'd16: r = 27'sd256;
      5'd17: r = 27'sd128;
      5'd18: r = 27'sd64;
      5'd19: r = 27'sd32;
      5'd20: r = 27'sd16;
      5'd21: r = 27'sd8;
      5'd22: r = 27'sd4;
      5'd23: r = 27'sd2;
      default: r = 27'sd0;
    endcase
    return r;
  endfunction
endpackage

/* rtl/core/e2q_fold.sv */
// Entry stage: halves each angle, folds it into +-pi/2 and seeds the CORDIC lanes.
// Depends on e2q_pkg.
module e2q_fold (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [15:0]     roll,
  input  logic signed [15:0]     pitch,
  input  logic signed [15:0]     yaw,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output e2q_pkg::lanes_t        dn_lanes
);
  import e2q_pkg::*;

  logic signed [15:0] ang [3];
  lanes_t             seed;

  assign ang[0] = roll;
  assign ang[1] = pitch;
  assign ang[2] = yaw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [27:0] h;
      logic signed [27:0] f;
      h = {{2{ang[k][15]}}, ang[k], 10'b0};
      f = h;
      seed[k].flip = 1'b0;
      if (h > HALF_PI_Q24) begin
        f = PI_Q24 - h;
        seed[k].flip = 1'b1;
      end else if (h < -HALF_PI_Q24) begin
        f = -PI_Q24 - h;
        seed[k].flip = 1'b1;
      end
      seed[k].x = GAIN_Q30;
      seed[k].y = '0;
      seed[k].z = f[26:0];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_lanes <= seed;
    end
  end
endmodule

/* rtl/core/e2q_cordic_cell.sv */
// One CORDIC micro-rotation for all three angle lanes, registered.
// Depends on e2q_pkg; the stage index comes in as a tied-off port.
module e2q_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [e2q_pkg::IDX_W-1:0]   idx,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  e2q_pkg::lanes_t             up_lanes,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output e2q_pkg::lanes_t             dn_lanes
);
  import e2q_pkg::*;

  lanes_t             rot;
  logic signed [26:0] step;

  assign step = atan_q24(idx);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      dx = up_lanes[k].y >>> idx;
      dy = up_lanes[k].x >>> idx;
      rot[k].flip = up_lanes[k].flip;
      if (!up_lanes[k].z[26]) begin
        rot[k].x = up_lanes[k].x - dx;
        rot[k].y = up_lanes[k].y + dy;
        rot[k].z = up_lanes[k].z - step;
      end else begin
        rot[k].x = up_lanes[k].x + dx;
        rot[k].y = up_lanes[k].y - dy;
        rot[k].z = up_lanes[k].z + step;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_lanes <= rot;
    end
  end
endmodule

/* rtl/core/e2q_quat.sv */
// Quaternion assembly: sin/cos rounding, pair products, triple products,
// then sum, round, saturate. Four registered stages. Depends on e2q_pkg.
module e2q_quat (
  input  logic               clk,
  input  logic               rst,
  input  logic               conv,
  input  logic               up_valid,
  output logic               up_ready,
  input  e2q_pkg::lanes_t    up_lanes,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [15:0] qx,
  output logic signed [15:0] qy,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw
);
  import e2q_pkg::*;

  logic [3:0] v;
  logic [3:0] rdy;

  // stage 1: sine/cosine per lane, Q.20
  logic signed [21:0] s1 [3];
  logic signed [21:0] c1 [3];
  // stage 2: pair products rounded to Q.20, plus yaw terms
  logic signed [23:0] p_sc, p_cs, p_cc, p_ss;
  logic signed [21:0] sy2, cy2;
  // stage 3: triple products Q.40
  logic signed [45:0] t [8];

  logic signed [21:0] s_n [3];
  logic signed [21:0] c_n [3];
  logic signed [23:0] pr_n [4];
  logic signed [15:0] res [4];

  assign rdy[3] = !v[3] || dn_ready;
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= up_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [33:0] ty;
      logic signed [33:0] tx;
      ty = 34'(up_lanes[k].y) + 34'sd512;
      tx = up_lanes[k].flip ? 34'sd512 - 34'(up_lanes[k].x)
                            : 34'(up_lanes[k].x) + 34'sd512;
      s_n[k] = ty[31:10];
      c_n[k] = tx[31:10];
    end
  end

  function automatic logic signed [23:0] pair(input logic signed [21:0] a,
                                              input logic signed [21:0] b);
    logic signed [44:0] m;
    m = 45'(a * b) + 45'sd524288;
    return m[43:20];
  endfunction

  always_comb begin
    pr_n[0] = pair(s1[0], c1[1]);  // sr*cp
    pr_n[1] = pair(c1[0], s1[1]);  // cr*sp
    pr_n[2] = pair(c1[0], c1[1]);  // cr*cp
    pr_n[3] = pair(s1[0], s1[1]);  // sr*sp
  end

  function automatic logic signed [15:0] to_q15(input logic signed [45:0] a,
                                                input logic signed [45:0] b,
                                                input logic               sub);
    logic signed [46:0] sum;
    logic signed [21:0] r;
    sum = sub ? 47'(a) - 47'(b) : 47'(a) + 47'(b);
    sum = sum + 47'sd16777216;
    r = sum[46:25];
    if (r > 22'sd32767) return 16'sh7fff;
    else if (r < -22'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_comb begin
    res[0] = to_q15(t[0], t[1], 1'b1);  // a
    res[1] = to_q15(t[2], t[3], 1'b0);  // b
    res[2] = to_q15(t[4], t[5], 1'b1);  // c
    res[3] = to_q15(t[6], t[7], 1'b0);  // d
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      s1 <= s_n;
      c1 <= c_n;
    end
    if (rdy[1] && v[0]) begin
      p_sc <= pr_n[0];
      p_cs <= pr_n[1];
      p_cc <= pr_n[2];
      p_ss <= pr_n[3];
      sy2  <= s1[2];
      cy2  <= c1[2];
    end
    if (rdy[2] && v[1]) begin
      t[0] <= p_sc * cy2;
      t[1] <= p_cs * sy2;
      t[2] <= p_cs * cy2;
      t[3] <= p_sc * sy2;
      t[4] <= p_cc * sy2;
      t[5] <= p_ss * cy2;
      t[6] <= p_cc * cy2;
      t[7] <= p_ss * sy2;
    end
    if (rdy[3] && v[2]) begin
      qx <= conv ? res[1] : res[0];
      qy <= conv ? res[2] : res[1];
      qz <= conv ? res[0] : res[2];
      qw <= res[3];
    end
  end
endmodule

/* rtl/core/euler_to_quaternion.sv */
// Top level: APB convention register, entry fold, CORDIC cell chain, quaternion stages.
// Depends on e2q_pkg, e2q_fold, e2q_cordic_cell, e2q_quat and the macros header.
//
//   channel  | valid      | stall      | beat fields
//   ---------+------------+------------+-------------------
//   pose in  | pose_valid | pose_stall | roll, pitch, yaw
//   quat out | quat_valid | quat_stall | qx, qy, qz, qw
//
// One beat per cycle sustained while quat_stall is low; the path is the
// fold stage, one cell per CORDIC iteration and four quaternion stages.
// Every stage holds one beat and fills bubbles, so pose_stall rises only
// when the whole chain is full and the output is stalled.
// Synchronous active-high reset clears all valid bits and convention to 0.
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               pose_valid,
  output logic               pose_stall,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] yaw,
  output logic               quat_valid,
  input  logic               quat_stall,
  output logic signed [15:0] qx,
  output logic signed [15:0] qy,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw
);
  import e2q_pkg::*;

  logic   conv;
  logic   wr;
  logic   fold_ready;
  logic   cv [CORDIC_STAGES+1];
  logic   cr [CORDIC_STAGES+1];
  lanes_t cl [CORDIC_STAGES+1];

  // single word register; every offset maps to it
  assign wr     = psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0);
  assign pready = 1'b1;
  assign prdata = {31'b0, conv};

  always_ff @(posedge clk) begin
    if (rst) begin
      conv <= 1'b0;
    end else if (wr) begin
      conv <= pwdata[0];
    end
  end

  e2q_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pose_valid),
    .up_ready (fold_ready),
    .roll     (roll),
    .pitch    (pitch),
    .yaw      (yaw),
    .dn_valid (cv[0]),
    .dn_ready (cr[0]),
    .dn_lanes (cl[0])
  );

  assign pose_stall = !fold_ready;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_lanes (cl[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_lanes (cl[i+1])
    );
  end

  e2q_quat u_quat (
    .clk      (clk),
    .rst      (rst),
    .conv     (conv),
    .up_valid (cv[CORDIC_STAGES]),
    .up_ready (cr[CORDIC_STAGES]),
    .up_lanes (cl[CORDIC_STAGES]),
    .dn_valid (quat_valid),
    .dn_ready (!quat_stall),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .qw       (qw)
  );

  `E2Q_ASSERT(a_stall_means_full, clk, rst, pose_stall |-> quat_valid && quat_stall)
  `E2Q_ASSERT(a_conv_only_on_write, clk, rst, !wr |=> $stable(conv))
  `E2Q_NEVER(a_fold_stuck, clk, rst, cv[0] && !cr[0] && !quat_valid)
endmodule
